// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: design/jsd_pkg.sv
// Types, constants and codes of the job shop dispatch scheduler.
package jsd_pkg;

    localparam int MAX_JOBS      = 16;
    localparam int MAX_MACHINES  = 16;
    localparam int DURATION_BITS = 16;

    localparam int JOB_BITS      = $clog2(MAX_JOBS);
    localparam int MACH_BITS     = $clog2(MAX_MACHINES);
    localparam int SLOTS         = MAX_JOBS * MAX_MACHINES;
    localparam int SLOT_BITS     = $clog2(SLOTS);
    localparam int JC_BITS       = $clog2(MAX_JOBS + 1);
    localparam int MC_BITS       = $clog2(MAX_MACHINES + 1);
    localparam int WORK_BITS     = 20;
    localparam int TIME_BITS     = 32;
    localparam int KEY_BITS      = TIME_BITS + 1;
    localparam int SCAN_LAST     = MAX_JOBS + 1;
    localparam int SCAN_BITS     = $clog2(SCAN_LAST + 1);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RULE      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_JOB_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MACH_CNT  = 2'd2;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_RESTART  = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam logic [2:0] RULE_SPT = 3'd0;
    localparam logic [2:0] RULE_LPT = 3'd1;
    localparam logic [2:0] RULE_MWR = 3'd2;
    localparam logic [2:0] RULE_LWR = 3'd3;
    localparam logic [2:0] RULE_EST = 3'd4;
    localparam logic [2:0] RULE_ECT = 3'd5;

    localparam logic STATUS_SCHEDULED = 1'b0;
    localparam logic STATUS_NONE_LEFT = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  job;
        logic [3:0]  step;
        logic [3:0]  machine;
        logic [15:0] duration;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [3:0]  chosen_job;
        logic [3:0]  chosen_step;
        logic [3:0]  chosen_machine;
        logic [31:0] start_time;
        logic [31:0] finish_time;
        logic [31:0] makespan;
        logic        last;
    } t_out;

    typedef struct packed {
        logic                load;
        logic                restart;
        logic                clear_tot;
        logic                scan_clr;
        logic                issue;
        logic [JOB_BITS-1:0] idx;
        logic                commit;
        logic                report;
    } t_ctl;

    typedef struct packed {
        logic found;
    } t_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

endpackage

// File: design/job_shop_dispatch_scheduler.sv
// Top level of the job shop dispatch scheduler: controller, datapath and checks.
//
//   channel   handshake                 payload
//   command   start / busy              i_item (jsd_pkg::t_in)
//   result    o_result_valid (strobe)   o_result (jsd_pkg::t_out)
//   config    i_cfg_we                  i_cfg_index, i_cfg_data
//
// Load, restart and clear-totals beats are handled directly in idle; busy stays low.
// A dispatch beat keeps busy high while the scan runs, one job per cycle
// through the operation table read port; then the pipeline drains and the update commits.
// The result strobe rises in the same cycle that busy falls; a new beat may enter then.
// Reset clears all job, machine and makespan state and totals; the operation table
// holds garbage until loaded. The receiver cannot stall results.
`include "assert_macros.svh"

module job_shop_dispatch_scheduler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  jsd_pkg::t_in                       i_item,
    output logic                               o_result_valid,
    output jsd_pkg::t_out                      o_result,
    input  logic                               i_cfg_we,
    input  logic [jsd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [jsd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    jsd_pkg::t_ctl w_ctl;
    jsd_pkg::t_sts w_sts;

    jsd_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_item.command),
        .i_sts     (w_sts),
        .o_ctl     (w_ctl),
        .busy      (busy)
    );

    jsd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_sts          (w_sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    `ASSERT_CLK(a_dispatch_goes_busy, i_clk, i_rst_n, (start && !busy && i_item.command == jsd_pkg::CMD_DISPATCH) |=> busy, "dispatch beat did not start a scan")
    `ASSERT_CLK(a_report_gives_beat, i_clk, i_rst_n, w_ctl.report |=> o_result_valid, "report cycle produced no result beat")
    `ASSERT_CLK(a_beat_from_report, i_clk, i_rst_n, o_result_valid |-> $past(w_ctl.report), "result beat without a report cycle")
    `ASSERT_NEVER(a_no_beat_while_busy, i_clk, i_rst_n, o_result_valid && busy, "result beat while a scan is running")

endmodule

// File: design/jsd_datapath.sv
// Datapath: operation table, job and machine state, candidate scan pipeline, result register.
module jsd_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  jsd_pkg::t_ctl                      i_ctl,
    input  jsd_pkg::t_in                       i_item,
    input  logic                               i_cfg_we,
    input  logic [jsd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [jsd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output jsd_pkg::t_sts                      o_sts,
    output jsd_pkg::t_out                      o_result,
    output logic                               o_result_valid
);

    // configuration
    logic [2:0]                         r_rule;
    logic [jsd_pkg::CFG_DATA_BITS-1:0]  r_job_count;
    logic [jsd_pkg::CFG_DATA_BITS-1:0]  r_mach_count;
    logic [jsd_pkg::JC_BITS-1:0]        w_jc;
    logic [jsd_pkg::MC_BITS-1:0]        w_mc;

    // operation table
    logic [jsd_pkg::MACH_BITS-1:0]      r_op_mach [jsd_pkg::SLOTS];
    logic [jsd_pkg::DURATION_BITS-1:0]  r_op_dur  [jsd_pkg::SLOTS];
    logic [jsd_pkg::MACH_BITS-1:0]      r_rd_mach;
    logic [jsd_pkg::DURATION_BITS-1:0]  r_rd_dur;
    logic [jsd_pkg::SLOT_BITS-1:0]      w_wr_addr;
    logic [jsd_pkg::SLOT_BITS-1:0]      w_rd_addr;
    logic                               w_wr_ok;

    // job and machine state
    logic [jsd_pkg::WORK_BITS-1:0]      r_total  [jsd_pkg::MAX_JOBS];
    logic [jsd_pkg::WORK_BITS-1:0]      r_remain [jsd_pkg::MAX_JOBS];
    logic [jsd_pkg::MC_BITS-1:0]        r_next   [jsd_pkg::MAX_JOBS];
    logic [jsd_pkg::TIME_BITS-1:0]      r_ready  [jsd_pkg::MAX_JOBS];
    logic [jsd_pkg::TIME_BITS-1:0]      r_free   [jsd_pkg::MAX_MACHINES];
    logic [jsd_pkg::TIME_BITS-1:0]      r_makespan;

    // scan pipeline
    logic                               r_p1_valid;
    logic [jsd_pkg::JOB_BITS-1:0]       r_p1_job;
    logic                               r_p2_valid;
    logic [jsd_pkg::JOB_BITS-1:0]       r_p2_job;
    logic [jsd_pkg::MACH_BITS-1:0]      r_p2_step;
    logic [jsd_pkg::MACH_BITS-1:0]      r_p2_mach;
    logic [jsd_pkg::DURATION_BITS-1:0]  r_p2_dur;
    logic [jsd_pkg::TIME_BITS-1:0]      r_p2_start;
    logic [jsd_pkg::TIME_BITS-1:0]      r_p2_fin;
    logic [jsd_pkg::KEY_BITS-1:0]       r_p2_key;
    logic                               r_found;
    logic [jsd_pkg::JOB_BITS-1:0]       r_best_job;
    logic [jsd_pkg::MACH_BITS-1:0]      r_best_step;
    logic [jsd_pkg::MACH_BITS-1:0]      r_best_mach;
    logic [jsd_pkg::DURATION_BITS-1:0]  r_best_dur;
    logic [jsd_pkg::TIME_BITS-1:0]      r_best_start;
    logic [jsd_pkg::TIME_BITS-1:0]      r_best_fin;
    logic [jsd_pkg::KEY_BITS-1:0]       r_best_key;

    logic [jsd_pkg::TIME_BITS-1:0]      w_s2_ready;
    logic [jsd_pkg::TIME_BITS-1:0]      w_s2_free;
    logic [jsd_pkg::TIME_BITS-1:0]      w_s2_start;
    logic [jsd_pkg::KEY_BITS-1:0]       w_s2_sum;
    logic [jsd_pkg::TIME_BITS-1:0]      w_s2_fin;
    logic [jsd_pkg::KEY_BITS-1:0]       w_s2_key;
    logic                               w_max_rule;
    logic                               w_better;

    logic [jsd_pkg::WORK_BITS-1:0]      w_best_remain;
    logic [jsd_pkg::WORK_BITS-1:0]      w_new_remain;
    logic [jsd_pkg::TIME_BITS-1:0]      w_new_makespan;
    logic                               w_any_left;

    jsd_pkg::t_out                      r_result;

    logic                               r_res_valid;

    always_comb begin
        if (r_job_count == '0) begin
            w_jc = jsd_pkg::JC_BITS'(1);
        end else if (32'(r_job_count) > jsd_pkg::MAX_JOBS) begin
            w_jc = jsd_pkg::JC_BITS'(jsd_pkg::MAX_JOBS);
        end else begin
            w_jc = jsd_pkg::JC_BITS'(r_job_count);
        end
        if (r_mach_count == '0) begin
            w_mc = jsd_pkg::MC_BITS'(1);
        end else if (32'(r_mach_count) > jsd_pkg::MAX_MACHINES) begin
            w_mc = jsd_pkg::MC_BITS'(jsd_pkg::MAX_MACHINES);
        end else begin
            w_mc = jsd_pkg::MC_BITS'(r_mach_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule       <= jsd_pkg::RULE_SPT;
            r_job_count  <= jsd_pkg::CFG_DATA_BITS'(jsd_pkg::MAX_JOBS);
            r_mach_count <= jsd_pkg::CFG_DATA_BITS'(jsd_pkg::MAX_MACHINES);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jsd_pkg::CFG_RULE:      r_rule       <= i_cfg_data[2:0];
                jsd_pkg::CFG_JOB_COUNT: r_job_count  <= i_cfg_data;
                jsd_pkg::CFG_MACH_CNT:  r_mach_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operation table: one write port, one registered read port
    assign w_wr_ok   = (32'(i_item.job) < jsd_pkg::MAX_JOBS)
                    && (32'(i_item.step) < jsd_pkg::MAX_MACHINES);
    assign w_wr_addr = jsd_pkg::SLOT_BITS'(32'(i_item.job) * jsd_pkg::MAX_MACHINES
                                          + 32'(i_item.step));
    assign w_rd_addr = jsd_pkg::SLOT_BITS'(32'(i_ctl.idx) * jsd_pkg::MAX_MACHINES
                                          + 32'(r_next[i_ctl.idx][jsd_pkg::MACH_BITS-1:0]));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_wr_ok) begin
            r_op_mach[w_wr_addr] <= jsd_pkg::MACH_BITS'(i_item.machine);
            r_op_dur[w_wr_addr]  <= jsd_pkg::DURATION_BITS'(i_item.duration);
        end
        r_rd_mach <= r_op_mach[w_rd_addr];
        r_rd_dur  <= r_op_dur[w_rd_addr];
    end

    // stage 2: earliest start and rule key
    always_comb begin
        w_s2_ready = r_ready[r_p1_job];
        w_s2_free  = r_free[r_rd_mach];
        w_s2_start = (w_s2_ready > w_s2_free) ? w_s2_ready : w_s2_free;
        w_s2_sum   = jsd_pkg::KEY_BITS'(w_s2_start) + jsd_pkg::KEY_BITS'(r_rd_dur);
        w_s2_fin   = w_s2_sum[jsd_pkg::TIME_BITS] ? '1 : w_s2_sum[jsd_pkg::TIME_BITS-1:0];
        case (r_rule)
            jsd_pkg::RULE_LPT: w_s2_key = jsd_pkg::KEY_BITS'(r_rd_dur);
            jsd_pkg::RULE_MWR: w_s2_key = jsd_pkg::KEY_BITS'(r_remain[r_p1_job]);
            jsd_pkg::RULE_LWR: w_s2_key = jsd_pkg::KEY_BITS'(r_remain[r_p1_job]);
            jsd_pkg::RULE_EST: w_s2_key = jsd_pkg::KEY_BITS'(w_s2_start);
            jsd_pkg::RULE_ECT: w_s2_key = w_s2_sum;
            default:           w_s2_key = jsd_pkg::KEY_BITS'(r_rd_dur);
        endcase
    end

    // stage 3: keep the best candidate, lowest job wins ties
    assign w_max_rule = (r_rule == jsd_pkg::RULE_LPT) || (r_rule == jsd_pkg::RULE_MWR);
    assign w_better   = !r_found || (w_max_rule ? (r_p2_key > r_best_key)
                                                : (r_p2_key < r_best_key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_p1_valid <= i_ctl.issue
                       && (jsd_pkg::JC_BITS'(i_ctl.idx) < w_jc)
                       && (r_next[i_ctl.idx] < w_mc);
            r_p2_valid <= r_p1_valid;
            if (i_ctl.scan_clr) begin
                r_found <= 1'b0;
            end else if (r_p2_valid && w_better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_job   <= i_ctl.idx;
        r_p2_job   <= r_p1_job;
        r_p2_step  <= r_next[r_p1_job][jsd_pkg::MACH_BITS-1:0];
        r_p2_mach  <= r_rd_mach;
        r_p2_dur   <= r_rd_dur;
        r_p2_start <= w_s2_start;
        r_p2_fin   <= w_s2_fin;
        r_p2_key   <= w_s2_key;
        if (r_p2_valid && w_better) begin
            r_best_job   <= r_p2_job;
            r_best_step  <= r_p2_step;
            r_best_mach  <= r_p2_mach;
            r_best_dur   <= r_p2_dur;
            r_best_start <= r_p2_start;
            r_best_fin   <= r_p2_fin;
            r_best_key   <= r_p2_key;
        end
    end

    // commit the chosen operation
    assign w_best_remain  = r_remain[r_best_job];
    assign w_new_remain   = (w_best_remain > jsd_pkg::WORK_BITS'(r_best_dur))
                          ? w_best_remain - jsd_pkg::WORK_BITS'(r_best_dur) : '0;
    assign w_new_makespan = (r_best_fin > r_makespan) ? r_best_fin : r_makespan;

    always_comb begin
        logic [jsd_pkg::MC_BITS-1:0] nxt;
        w_any_left = 1'b0;
        for (int j = 0; j < jsd_pkg::MAX_JOBS; j++) begin
            nxt = r_next[j];
            if (r_found && (r_best_job == jsd_pkg::JOB_BITS'(j))) begin
                nxt = nxt + jsd_pkg::MC_BITS'(1);
            end
            if ((jsd_pkg::JC_BITS'(j) < w_jc) && (nxt < w_mc)) begin
                w_any_left = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < jsd_pkg::MAX_JOBS; j++) begin
                r_total[j]  <= '0;
                r_remain[j] <= '0;
                r_next[j]   <= '0;
                r_ready[j]  <= '0;
            end
            for (int m = 0; m < jsd_pkg::MAX_MACHINES; m++) begin
                r_free[m] <= '0;
            end
            r_makespan <= '0;
        end else begin
            if (i_ctl.load && w_wr_ok) begin
                r_total[i_item.job] <= r_total[i_item.job]
                                     + jsd_pkg::WORK_BITS'(i_item.duration);
            end
            if (i_ctl.clear_tot) begin
                for (int j = 0; j < jsd_pkg::MAX_JOBS; j++) begin
                    r_total[j] <= '0;
                end
            end
            if (i_ctl.restart) begin
                for (int j = 0; j < jsd_pkg::MAX_JOBS; j++) begin
                    r_remain[j] <= r_total[j];
                    r_next[j]   <= '0;
                    r_ready[j]  <= '0;
                end
                for (int m = 0; m < jsd_pkg::MAX_MACHINES; m++) begin
                    r_free[m] <= '0;
                end
                r_makespan <= '0;
            end
            if (i_ctl.commit) begin
                r_ready[r_best_job]  <= r_best_fin;
                r_free[r_best_mach]  <= r_best_fin;
                r_remain[r_best_job] <= w_new_remain;
                r_next[r_best_job]   <= r_next[r_best_job] + jsd_pkg::MC_BITS'(1);
                r_makespan           <= w_new_makespan;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_ctl.report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.report) begin
            if (r_found) begin
                r_result.status         <= jsd_pkg::STATUS_SCHEDULED;
                r_result.chosen_job     <= 4'(r_best_job);
                r_result.chosen_step    <= 4'(r_best_step);
                r_result.chosen_machine <= 4'(r_best_mach);
                r_result.start_time     <= r_best_start;
                r_result.finish_time    <= r_best_fin;
                r_result.makespan       <= w_new_makespan;
                r_result.last           <= !w_any_left;
            end else begin
                r_result.status         <= jsd_pkg::STATUS_NONE_LEFT;
                r_result.chosen_job     <= '0;
                r_result.chosen_step    <= '0;
                r_result.chosen_machine <= '0;
                r_result.start_time     <= '0;
                r_result.finish_time    <= '0;
                r_result.makespan       <= r_makespan;
                r_result.last           <= 1'b0;
            end
        end
    end

    assign o_sts.found    = r_found;
    assign o_result       = r_result;
    assign o_result_valid = r_res_valid;

endmodule

// File: design/jsd_controller.sv
// Controller: command decode and scan sequencing for the dispatch scheduler.
module jsd_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [1:0]    i_command,
    input  jsd_pkg::t_sts i_sts,
    output jsd_pkg::t_ctl o_ctl,
    output logic          busy
);

    jsd_pkg::t_state                r_state;
    jsd_pkg::t_state                n_state;
    logic [jsd_pkg::SCAN_BITS-1:0]  r_scan_idx;
    logic [jsd_pkg::SCAN_BITS-1:0]  n_scan_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= jsd_pkg::S_IDLE;
            r_scan_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_scan_idx = r_scan_idx;
        o_ctl      = '0;
        o_ctl.idx  = r_scan_idx[jsd_pkg::JOB_BITS-1:0];
        case (r_state)
            jsd_pkg::S_IDLE: begin
                if (start) begin
                    case (i_command)
                        jsd_pkg::CMD_LOAD:     o_ctl.load      = 1'b1;
                        jsd_pkg::CMD_RESTART:  o_ctl.restart   = 1'b1;
                        jsd_pkg::CMD_CLEAR:    o_ctl.clear_tot = 1'b1;
                        jsd_pkg::CMD_DISPATCH: begin
                            o_ctl.scan_clr = 1'b1;
                            n_scan_idx     = '0;
                            n_state        = jsd_pkg::S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            jsd_pkg::S_SCAN: begin
                o_ctl.issue = (32'(r_scan_idx) < jsd_pkg::MAX_JOBS);
                if (r_scan_idx == jsd_pkg::SCAN_BITS'(jsd_pkg::SCAN_LAST)) begin
                    n_state = jsd_pkg::S_UPDATE;
                end else begin
                    n_scan_idx = r_scan_idx + jsd_pkg::SCAN_BITS'(1);
                end
            end
            jsd_pkg::S_UPDATE: begin
                o_ctl.commit = i_sts.found;
                o_ctl.report = 1'b1;
                n_state      = jsd_pkg::S_IDLE;
            end
            default: begin
                n_state = jsd_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != jsd_pkg::S_IDLE);

endmodule
